>>> hdl/tbie_pkg.sv
// ----------------------------------------------------------------------------
// TLSF bucket index engine package
// Shared widths, default parameter values, action and status codes, and the
// size mapping record used by the bucket index engine.
// ----------------------------------------------------------------------------
package tbie_pkg;

   localparam int unsigned DEF_FIRST_LEVEL_OFFSET = 8;
   localparam int unsigned DEF_SECOND_LEVEL_LOG   = 5;
   localparam int unsigned DEF_FIRST_LEVEL_COUNT  = 24;
   localparam int unsigned DEF_COUNT_WIDTH        = 16;

   localparam int unsigned ACTION_WIDTH = 2;
   localparam int unsigned BYTES_WIDTH  = 31;
   localparam int unsigned LEVEL_WIDTH  = 5;
   localparam int unsigned TOTAL_WIDTH  = 32;
   localparam int unsigned STATUS_WIDTH = 2;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_SEARCH = 2'd2
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK       = 2'd0,
      ST_NO_BLOCK = 2'd1,
      ST_RANGE    = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic                   ok;
      logic [LEVEL_WIDTH-1:0] fl;
      logic [LEVEL_WIDTH-1:0] sl;
   } map_type;

endpackage

>>> hdl/tlsf_bucket_index_engine_unit.sv
// ----------------------------------------------------------------------------
// TLSF bucket index engine
// Two-level segregated-fit bookkeeping: per-bucket free block counts, the
// first- and second-level bitmaps, a saturating free byte total, and a
// rounded masked find-first-set search for a suitable bucket.
// ----------------------------------------------------------------------------
// Usage:
// Each request transfer carries an action (insert, remove or search) and a
// block size. Every request produces exactly one response transfer with the
// found flag, the first- and second-level indices, the free byte total after
// the request, and a status code.
// The engine is a two-stage pipeline. The size is mapped and the bucket count
// memory is read when the request is taken; the count, bitmaps and total are
// updated and the response is registered in the second stage. One request is
// taken every cycle while rsp_stall does not hold the pipeline. The count
// memory has one read and one write port with a bypass for back-to-back
// requests to the same bucket.
// When a response waits and rsp_stall is high, the whole pipeline holds and
// req_stall is raised in the same cycle.
// Reset clears the bitmaps, the free total and the pipeline at once. The count
// memory is not cleared: a count is used only where its bitmap bit is set, so
// requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module tlsf_bucket_index_engine_unit #(
   parameter int unsigned FIRST_LEVEL_OFFSET = tbie_pkg::DEF_FIRST_LEVEL_OFFSET,
   parameter int unsigned SECOND_LEVEL_LOG   = tbie_pkg::DEF_SECOND_LEVEL_LOG,
   parameter int unsigned FIRST_LEVEL_COUNT  = tbie_pkg::DEF_FIRST_LEVEL_COUNT,
   parameter int unsigned COUNT_WIDTH        = tbie_pkg::DEF_COUNT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tbie_pkg::ACTION_WIDTH-1:0] req_action,
   input  logic [tbie_pkg::BYTES_WIDTH-1:0]  req_block_bytes,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [tbie_pkg::LEVEL_WIDTH-1:0]  rsp_first_level,
   output logic [tbie_pkg::LEVEL_WIDTH-1:0]  rsp_second_level,
   output logic [tbie_pkg::TOTAL_WIDTH-1:0]  rsp_free_bytes,
   output logic [tbie_pkg::STATUS_WIDTH-1:0] rsp_status
);

   import tbie_pkg::*;

   localparam int unsigned SL_COUNT = 1 << SECOND_LEVEL_LOG;
   localparam int unsigned BUCKETS  = FIRST_LEVEL_COUNT * SL_COUNT;
   localparam int unsigned FL_IDX_W = $clog2(FIRST_LEVEL_COUNT);
   localparam int unsigned ADDR_W   = FL_IDX_W + SECOND_LEVEL_LOG;

   function automatic logic [5:0] top_bit(input logic [31:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            n = 6'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [LEVEL_WIDTH-1:0] low_bit(input logic [31:0] v);
      logic [LEVEL_WIDTH-1:0] n;
      n = '0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) begin
            n = LEVEL_WIDTH'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] round_up(input logic [BYTES_WIDTH-1:0] b);
      logic [31:0] req;
      logic [5:0]  m;
      req = 32'(b);
      m   = top_bit(req);
      if (req >= (32'd1 << FIRST_LEVEL_OFFSET) && m >= 6'(SECOND_LEVEL_LOG)) begin
         req = req + ((32'd1 << (m - 6'(SECOND_LEVEL_LOG))) - 32'd1);
      end
      return req;
   endfunction

   function automatic map_type map_size(input logic [31:0] size);
      logic [31+SECOND_LEVEL_LOG:0] ext;
      logic [31+SECOND_LEVEL_LOG:0] sh;
      logic [5:0]                   m;
      logic [5:0]                   f;
      map_type                      r;
      ext = {size, {SECOND_LEVEL_LOG{1'b0}}};
      m   = top_bit(size);
      f   = m - 6'(FIRST_LEVEL_OFFSET - 1);
      r   = '0;
      if (size < (32'd1 << FIRST_LEVEL_OFFSET)) begin
         sh                      = ext >> FIRST_LEVEL_OFFSET;
         r.ok                    = 1'b1;
         r.sl[SECOND_LEVEL_LOG-1:0] = sh[SECOND_LEVEL_LOG-1:0];
      end else if (f < 6'(FIRST_LEVEL_COUNT)) begin
         sh                      = ext >> m;
         r.ok                    = 1'b1;
         r.fl                    = f[LEVEL_WIDTH-1:0];
         r.sl[SECOND_LEVEL_LOG-1:0] = sh[SECOND_LEVEL_LOG-1:0];
      end
      return r;
   endfunction

   logic                         en;
   logic                         accept;
   map_type                      ins_map;
   map_type                      srch_map;
   logic [ADDR_W-1:0]            rd_addr;

   logic                         p_valid_ff;
   logic [ACTION_WIDTH-1:0]      p_action_ff;
   logic [BYTES_WIDTH-1:0]       p_bytes_ff;
   map_type                      p_map_ff;
   logic [COUNT_WIDTH-1:0]       p_count_ff;

   logic [COUNT_WIDTH-1:0]       cnt_mem [BUCKETS];

   logic [FIRST_LEVEL_COUNT-1:0] l1_ff;
   logic [FIRST_LEVEL_COUNT-1:0] l1_in;
   logic [SL_COUNT-1:0]          l2_ff [FIRST_LEVEL_COUNT];
   logic [SL_COUNT-1:0]          l2_in [FIRST_LEVEL_COUNT];
   logic [TOTAL_WIDTH-1:0]       total_ff;
   logic [TOTAL_WIDTH-1:0]       total_in;

   logic [FL_IDX_W-1:0]          p_row;
   logic [SECOND_LEVEL_LOG-1:0]  p_col;
   logic [ADDR_W-1:0]            wr_addr;
   logic                         wr_en;
   logic [COUNT_WIDTH-1:0]       wr_count;
   logic [SL_COUNT-1:0]          row_cur;
   logic [SL_COUNT-1:0]          row_hit;
   logic [SL_COUNT-1:0]          row_left;
   logic [FIRST_LEVEL_COUNT-1:0] upper;
   logic [LEVEL_WIDTH-1:0]       up_fl;
   logic [LEVEL_WIDTH-1:0]       row_low [FIRST_LEVEL_COUNT];
   logic                         present;
   logic [COUNT_WIDTH-1:0]       cnt_cur;
   logic [TOTAL_WIDTH:0]         sum;
   logic [TOTAL_WIDTH-1:0]       bytes_ext;

   logic                         found_in;
   logic [LEVEL_WIDTH-1:0]       fl_in;
   logic [LEVEL_WIDTH-1:0]       sl_in;
   status_type                   status_in;

   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic [LEVEL_WIDTH-1:0]       rsp_fl_ff;
   logic [LEVEL_WIDTH-1:0]       rsp_sl_ff;
   status_type                   rsp_status_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   assign ins_map  = map_size(32'(req_block_bytes));
   assign srch_map = map_size(round_up(req_block_bytes));
   assign rd_addr  = {ins_map.fl[FL_IDX_W-1:0], ins_map.sl[SECOND_LEVEL_LOG-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_action_ff <= req_action;
         p_bytes_ff  <= req_block_bytes;
         p_map_ff    <= (req_action == ACT_SEARCH) ? srch_map : ins_map;
         if (wr_en && wr_addr == rd_addr) begin
            p_count_ff <= wr_count;
         end else begin
            p_count_ff <= cnt_mem[rd_addr];
         end
         if (wr_en) begin
            cnt_mem[wr_addr] <= wr_count;
         end
      end
   end

   assign p_row     = p_map_ff.fl[FL_IDX_W-1:0];
   assign p_col     = p_map_ff.sl[SECOND_LEVEL_LOG-1:0];
   assign wr_addr   = {p_row, p_col};
   assign row_cur   = l2_ff[p_row];
   assign present   = row_cur[p_col];
   assign cnt_cur   = present ? p_count_ff : '0;
   assign row_left  = row_cur & ~(SL_COUNT'(1) << p_col);
   assign bytes_ext = TOTAL_WIDTH'(p_bytes_ff);
   assign sum       = {1'b0, total_ff} + {1'b0, bytes_ext};

   always_comb begin
      for (int i = 0; i < SL_COUNT; i++) begin
         row_hit[i] = row_cur[i] && (LEVEL_WIDTH'(i) >= p_map_ff.sl);
      end
      for (int i = 0; i < FIRST_LEVEL_COUNT; i++) begin
         upper[i]   = l1_ff[i] && (LEVEL_WIDTH'(i) > p_map_ff.fl);
         row_low[i] = low_bit(32'(l2_ff[i]));
      end
   end

   assign up_fl = low_bit(32'(upper));

   always_comb begin
      l1_in     = l1_ff;
      l2_in     = l2_ff;
      total_in  = total_ff;
      wr_en     = 1'b0;
      wr_count  = cnt_cur;
      found_in  = 1'b0;
      fl_in     = p_map_ff.fl;
      sl_in     = p_map_ff.sl;
      status_in = ST_OK;
      case (p_action_ff)
         ACT_INSERT: begin
            if (!p_map_ff.ok) begin
               status_in = ST_RANGE;
            end else begin
               wr_en               = en && p_valid_ff;
               wr_count            = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
               l2_in[p_row][p_col] = 1'b1;
               l1_in[p_row]        = 1'b1;
               total_in            = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
            end
         end
         ACT_REMOVE: begin
            if (!p_map_ff.ok) begin
               status_in = ST_RANGE;
            end else if (!present) begin
               status_in = ST_EMPTY;
            end else begin
               wr_en    = en && p_valid_ff;
               wr_count = cnt_cur - COUNT_WIDTH'(1);
               if (cnt_cur == COUNT_WIDTH'(1)) begin
                  l2_in[p_row] = row_left;
                  if (row_left == '0) begin
                     l1_in[p_row] = 1'b0;
                  end
               end
               total_in = (total_ff > bytes_ext) ? total_ff - bytes_ext : '0;
            end
         end
         ACT_SEARCH: begin
            if (!p_map_ff.ok) begin
               status_in = ST_RANGE;
            end else if (row_hit != '0) begin
               found_in = 1'b1;
               sl_in    = low_bit(32'(row_hit));
            end else if (upper != '0) begin
               found_in = 1'b1;
               fl_in    = up_fl;
               sl_in    = row_low[up_fl[FL_IDX_W-1:0]];
            end else begin
               status_in = ST_NO_BLOCK;
            end
         end
         default: begin
            fl_in     = '0;
            sl_in     = '0;
            status_in = ST_RANGE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff        <= '0;
         l2_ff        <= '{default: '0};
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p_valid_ff;
         if (p_valid_ff) begin
            l1_ff    <= l1_in;
            l2_ff    <= l2_in;
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_found_ff  <= found_in;
         rsp_fl_ff     <= fl_in;
         rsp_sl_ff     <= sl_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_first_level  = rsp_fl_ff;
   assign rsp_second_level = rsp_sl_ff;
   assign rsp_free_bytes   = total_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   for (genvar r = 0; r < FIRST_LEVEL_COUNT; r++) begin : g_map_check
      a_level_one_tracks_rows: assert property (@(posedge clock) disable iff (reset)
         l1_ff[r] == (l2_ff[r] != '0))
         else $error("first-level bit disagrees with its second-level row");
   end

   a_found_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == ST_OK)
      else $error("found response carries a failure status");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("request stalled while the response register can move");

   a_search_keeps_total: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(en && p_valid_ff && p_action_ff == ACT_SEARCH)
         |-> $stable(total_ff))
      else $error("search changed the free byte total");

   a_reset_empties_pipe: assert property (@(posedge clock)
      $past(reset) |-> !p_valid_ff && !rsp_valid_ff && total_ff == '0)
      else $error("pipeline not empty after reset");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLSF bucket index engine testbench
// Drives insert, remove and search requests with bursty request timing and a
// changing response stall pattern. A ledger class predicts every response
// from its own copy of the bitmaps, bucket counts and free byte total, and
// compares each response transfer field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import tbie_pkg::*;

   localparam int unsigned FLO      = DEF_FIRST_LEVEL_OFFSET;
   localparam int unsigned SLL      = DEF_SECOND_LEVEL_LOG;
   localparam int unsigned FLC      = DEF_FIRST_LEVEL_COUNT;
   localparam int unsigned CNT_W    = DEF_COUNT_WIDTH;
   localparam int unsigned SL_COUNT = 1 << SLL;

   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic                    found;
      logic [LEVEL_WIDTH-1:0]  first_level;
      logic [LEVEL_WIDTH-1:0]  second_level;
      logic [TOTAL_WIDTH-1:0]  free_bytes;
      status_type              status;
   } bucket_answer_type;

   class bucket_index_ledger;
      bit [FLC-1:0]         class_map;
      bit [SL_COUNT-1:0]    row_maps [FLC];
      bit [CNT_W-1:0]       block_counts [FLC*SL_COUNT];
      bit [TOTAL_WIDTH-1:0] free_sum;
      bucket_answer_type    awaited_answers [$];
      int                   mismatches;

      function new();
         class_map  = '0;
         free_sum   = '0;
         mismatches = 0;
         foreach (row_maps[i]) row_maps[i] = '0;
         foreach (block_counts[i]) block_counts[i] = '0;
      endfunction

      function int unsigned top_index(longint unsigned v);
         int unsigned n;
         n = 0;
         while (v > 1) begin
            v = v >> 1;
            n++;
         end
         return n;
      endfunction

      function int unsigned low_index(bit [31:0] v);
         int unsigned n;
         n = 0;
         if (v == 0) return 0;
         while (v[0] == 1'b0) begin
            v = v >> 1;
            n++;
         end
         return n;
      endfunction

      // Maps a size to its bucket; returns 0 when the class is beyond the table.
      function bit map_bytes(longint unsigned bytes, output int unsigned fl,
                             output int unsigned sl);
         int unsigned msb;
         if (bytes < (64'd1 << FLO)) begin
            fl = 0;
            sl = 32'((bytes >> (FLO - SLL)) & (SL_COUNT - 1));
            return 1'b1;
         end
         msb = top_index(bytes);
         fl  = msb - (FLO - 1);
         sl  = 32'((bytes >> (msb - SLL)) & (SL_COUNT - 1));
         if (fl >= FLC) begin
            fl = 0;
            sl = 0;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void book_request(logic [ACTION_WIDTH-1:0] act,
                                 logic [BYTES_WIDTH-1:0] bytes);
         bucket_answer_type a;
         int unsigned       fl;
         int unsigned       sl;
         int unsigned       idx;
         int unsigned       msb;
         longint unsigned   want;
         bit [SL_COUNT-1:0] row;
         bit [FLC-1:0]      upper;
         a.found  = 1'b0;
         a.status = ST_OK;
         fl = 0;
         sl = 0;
         case (act)
            ACT_INSERT, ACT_REMOVE: begin
               if (!map_bytes(64'(bytes), fl, sl)) begin
                  a.status = ST_RANGE;
               end else begin
                  idx = fl * SL_COUNT + sl;
                  if (act == ACT_INSERT) begin
                     if (block_counts[idx] != {CNT_W{1'b1}}) block_counts[idx]++;
                     row_maps[fl][sl] = 1'b1;
                     class_map[fl]    = 1'b1;
                     want = 64'(free_sum) + 64'(bytes);
                     free_sum = (want > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : want[31:0];
                  end else if (block_counts[idx] == 0) begin
                     a.status = ST_EMPTY;
                  end else begin
                     block_counts[idx]--;
                     if (block_counts[idx] == 0) begin
                        row_maps[fl][sl] = 1'b0;
                        if (row_maps[fl] == 0) class_map[fl] = 1'b0;
                     end
                     free_sum = (free_sum > 32'(bytes)) ? free_sum - 32'(bytes) : '0;
                  end
               end
            end
            ACT_SEARCH: begin
               want = 64'(bytes);
               if (want >= (64'd1 << FLO)) begin
                  msb = top_index(want);
                  if (msb >= SLL) want = want + (64'd1 << (msb - SLL)) - 64'd1;
               end
               if (!map_bytes(want, fl, sl)) begin
                  a.status = ST_RANGE;
               end else begin
                  row = row_maps[fl] & ({SL_COUNT{1'b1}} << sl);
                  if (row != 0) begin
                     sl      = low_index(32'(row));
                     a.found = 1'b1;
                  end else begin
                     upper = class_map & ({FLC{1'b1}} << (fl + 1));
                     if (upper == 0) begin
                        a.status = ST_NO_BLOCK;
                     end else begin
                        fl      = low_index(32'(upper));
                        sl      = low_index(32'(row_maps[fl]));
                        a.found = 1'b1;
                     end
                  end
               end
            end
            default: begin
               a.status = ST_RANGE;
            end
         endcase
         a.first_level  = fl[LEVEL_WIDTH-1:0];
         a.second_level = sl[LEVEL_WIDTH-1:0];
         a.free_bytes   = free_sum;
         awaited_answers.push_back(a);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
         end
      endfunction

      function void match_answer(logic found, logic [LEVEL_WIDTH-1:0] fl,
                                 logic [LEVEL_WIDTH-1:0] sl,
                                 logic [TOTAL_WIDTH-1:0] free,
                                 logic [STATUS_WIDTH-1:0] status);
         bucket_answer_type a;
         if (awaited_answers.size() == 0) begin
            mismatches++;
            $display("%0t: response transfer with none expected, actual %0h %0h %0h %0h %0h",
                     $time, found, fl, sl, free, status);
            return;
         end
         a = awaited_answers.pop_front();
         compare_field("found", 32'(a.found), 32'(found));
         compare_field("first_level", 32'(a.first_level), 32'(fl));
         compare_field("second_level", 32'(a.second_level), 32'(sl));
         compare_field("free_bytes", a.free_bytes, free);
         compare_field("status", 32'(a.status), 32'(status));
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [ACTION_WIDTH-1:0]  req_action;
   logic [BYTES_WIDTH-1:0]   req_block_bytes;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_found;
   logic [LEVEL_WIDTH-1:0]   rsp_first_level;
   logic [LEVEL_WIDTH-1:0]   rsp_second_level;
   logic [TOTAL_WIDTH-1:0]   rsp_free_bytes;
   logic [STATUS_WIDTH-1:0]  rsp_status;

   bucket_index_ledger ledger = new();
   int                 burst_left;
   logic [BYTES_WIDTH-1:0] live_sizes [$];

   tlsf_bucket_index_engine_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_block_bytes  (req_block_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_first_level  (rsp_first_level),
      .rsp_second_level (rsp_second_level),
      .rsp_free_bytes   (rsp_free_bytes),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         ledger.book_request(req_action, req_block_bytes);
      if (!reset && rsp_valid && !rsp_stall)
         ledger.match_answer(rsp_found, rsp_first_level, rsp_second_level,
                             rsp_free_bytes, rsp_status);
   end

   initial begin
      int level;
      int span;
      rsp_stall <= 1'b0;
      forever begin
         case ($urandom_range(0, 2))
            0:       level = 0;
            1:       level = 25;
            default: level = 65;
         endcase
         span = $urandom_range(16, 200);
         repeat (span) begin
            @(negedge clock);
            rsp_stall <= ($urandom_range(0, 99) < level);
         end
      end
   end

   task automatic send_request(input logic [ACTION_WIDTH-1:0] act,
                               input logic [BYTES_WIDTH-1:0] bytes);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_action      <= act;
      req_block_bytes <= bytes;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [BYTES_WIDTH-1:0] pick_size();
      int unsigned            m;
      logic [BYTES_WIDTH-1:0] base;
      m    = $urandom_range(FLO, BYTES_WIDTH - 1);
      base = 31'd1 << m;
      case ($urandom_range(0, 3))
         0:       return 31'($urandom_range(0, 255));
         1:       return base | (31'($urandom) & (base - 31'd1));
         2:       return 31'($urandom);
         default: return base + (31'($urandom_range(0, SL_COUNT - 1)) << (m - SLL))
                         - 31'($urandom_range(0, 1));
      endcase
   endfunction

   initial begin
      int                     roll;
      int                     k;
      logic [BYTES_WIDTH-1:0] sz;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_action      <= ACT_INSERT;
      req_block_bytes <= '0;
      burst_left       = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(ACT_SEARCH, 31'd0);
      send_request(ACT_REMOVE, 31'd0);
      send_request(ACT_INSERT, 31'd0);
      send_request(ACT_INSERT, 31'd255);
      send_request(ACT_INSERT, 31'd256);
      send_request(ACT_INSERT, 31'h7FFF_FFFF);
      send_request(ACT_INSERT, 31'h4000_0000);
      send_request(ACT_INSERT, 31'h4000_0000);
      send_request(ACT_SEARCH, 31'h7FFF_FFFF);
      send_request(ACT_SEARCH, 31'h4000_0001);
      send_request(ACT_SEARCH, 31'd1);
      send_request(ACT_SEARCH, 31'd257);
      send_request(ACT_SEARCH, 31'h2AAA_AAAA);
      send_request(ACT_UNUSED, 31'h7FFF_FFFF);
      send_request(ACT_UNUSED, 31'd0);
      send_request(ACT_REMOVE, 31'h7FFF_FFFF);
      send_request(ACT_REMOVE, 31'h4000_0000);
      send_request(ACT_REMOVE, 31'h4000_0000);
      send_request(ACT_SEARCH, 31'h1555_5555);
      send_request(ACT_REMOVE, 31'd256);
      send_request(ACT_REMOVE, 31'd255);
      send_request(ACT_REMOVE, 31'd0);
      send_request(ACT_REMOVE, 31'd0);
      send_request(ACT_SEARCH, 31'd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 38) begin
            sz = pick_size();
            live_sizes.push_back(sz);
            send_request(ACT_INSERT, sz);
         end else if (roll < 68) begin
            if (live_sizes.size() > 0 && $urandom_range(0, 4) != 0) begin
               k  = $urandom_range(0, live_sizes.size() - 1);
               sz = live_sizes[k];
               live_sizes.delete(k);
            end else begin
               sz = pick_size();
            end
            send_request(ACT_REMOVE, sz);
         end else if (roll < 95) begin
            send_request(ACT_SEARCH, pick_size());
         end else begin
            send_request(ACT_UNUSED, 31'($urandom));
         end
      end

      send_request(ACT_INSERT, 31'd0);
      send_request(ACT_SEARCH, 31'd0);
      send_request(ACT_REMOVE, 31'd3);
      send_request(ACT_SEARCH, 31'd5);
      req_valid <= 1'b0;

      while (ledger.awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
hdl/tbie_pkg.sv
hdl/tlsf_bucket_index_engine_unit.sv
sim/tb.sv
